@@ hw/rtl/bounded_random_index_generator_top_assert.svh @@
// assertion macros for the index generator
`ifndef BOUNDED_RANDOM_INDEX_GENERATOR_TOP_ASSERT_SVH
`define BOUNDED_RANDOM_INDEX_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRIG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BRIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/brig_pkg.sv @@
package brig_pkg;

    localparam int WORD_W = 64;
    localparam int STEP_W = $clog2(WORD_W);
    localparam int BOUND_W = 31;
    localparam int DEFAULT_MAX_BATCH = 64;

    localparam logic [WORD_W-1:0] INIT_WORD0 = 64'h180ec6d33cfd0aba;
    localparam logic [WORD_W-1:0] INIT_WORD1 = 64'hd5a61266f0c9392c;
    localparam logic [WORD_W-1:0] INIT_WORD2 = 64'ha9582618e03fc9aa;
    localparam logic [WORD_W-1:0] INIT_WORD3 = 64'h39abdc4529b1661c;

    localparam logic [WORD_W-1:0] SPLITMIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SPLITMIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SPLITMIX_MUL2 = 64'h94d049bb133111eb;

    localparam int XOSHIRO_SHIFT = 17;
    localparam int XOSHIRO_ROT = 45;

    typedef struct packed {
        logic [6:0] batch_count;
        logic signed [31:0] upper_bound;
    } in_item_t;

    typedef struct packed {
        logic [BOUND_W-1:0] index_value;
        logic last_flag;
        logic error_flag;
    } out_item_t;

    // one generator word written by the seed expander
    typedef struct packed {
        logic valid;
        logic [1:0] idx;
        logic [WORD_W-1:0] word;
    } seed_wr_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amount);
        rotl = (v << amount) | (v >> (WORD_W - amount));
    endfunction

endpackage

@@ hw/rtl/brig_mul.sv @@
module brig_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [brig_pkg::WORD_W-1:0] mcand,
    input  logic [brig_pkg::WORD_W-1:0] mplier,
    output logic                        done,
    output logic [brig_pkg::WORD_W-1:0] product
);
    import brig_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [WORD_W-1:0] mcand_reg;
    logic [WORD_W-1:0] mplier_reg;
    logic [WORD_W-1:0] acc_reg;
    logic              last_step;

    assign last_step = busy_reg && (cnt_reg == STEP_W'(WORD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // shift-add, one multiplier bit per cycle, low word kept
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ hw/rtl/brig_seed.sv @@
module brig_seed (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [brig_pkg::WORD_W-1:0] seed,
    output logic                        busy,
    output brig_pkg::seed_wr_t          wr
);
    import brig_pkg::*;

    typedef enum logic [5:0] {
        SD_IDLE = 6'b000001,
        SD_MIX1 = 6'b000010,
        SD_MUL1 = 6'b000100,
        SD_MIX2 = 6'b001000,
        SD_MUL2 = 6'b010000,
        SD_EMIT = 6'b100000
    } seed_state_t;

    seed_state_t       state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [WORD_W-1:0] acc_reg;
    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_done;
    logic [WORD_W-1:0] mul_p;

    brig_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mul_start  = 1'b0;
        mul_a      = acc_reg ^ (acc_reg >> 30);
        mul_b      = SPLITMIX_MUL1;
        unique case (state_reg)
            SD_IDLE:
            begin
                if (start)
                begin
                    state_next = SD_MIX1;
                    idx_next   = '0;
                end
            end
            SD_MIX1:
            begin
                mul_start  = 1'b1;
                state_next = SD_MUL1;
            end
            SD_MUL1:
            begin
                if (mul_done)
                begin
                    state_next = SD_MIX2;
                end
            end
            SD_MIX2:
            begin
                mul_start  = 1'b1;
                mul_a      = mul_p ^ (mul_p >> 27);
                mul_b      = SPLITMIX_MUL2;
                state_next = SD_MUL2;
            end
            SD_MUL2:
            begin
                if (mul_done)
                begin
                    state_next = SD_EMIT;
                end
            end
            SD_EMIT:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == 2'd3) ? SD_IDLE : SD_MIX1;
            end
            default:
            begin
                state_next = SD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // running splitmix counter, stepped once per emitted word
    always_ff @(posedge clk)
    begin
        if (state_reg == SD_IDLE && start)
        begin
            acc_reg <= seed + SPLITMIX_GAMMA;
        end
        else if (state_reg == SD_EMIT)
        begin
            acc_reg <= acc_reg + SPLITMIX_GAMMA;
        end
    end

    assign busy     = (state_reg != SD_IDLE);
    assign wr.valid = (state_reg == SD_EMIT);
    assign wr.idx   = idx_reg;
    assign wr.word  = mul_p ^ (mul_p >> 31);

endmodule

@@ hw/rtl/brig_mod.sv @@
module brig_mod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [brig_pkg::WORD_W-1:0]  dividend,
    input  logic [brig_pkg::BOUND_W-1:0] divisor,
    output logic                         done,
    output logic [brig_pkg::BOUND_W-1:0] remainder
);
    import brig_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [WORD_W-1:0]  dvd_reg;
    logic [BOUND_W-1:0] dsr_reg;
    logic [BOUND_W-1:0] rem_reg;
    logic [BOUND_W:0]   trial;
    logic [BOUND_W:0]   diff;
    logic [BOUND_W-1:0] rem_next;
    logic               last_step;

    // restoring step: one dividend bit enters the partial remainder
    assign trial     = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign rem_next  = (trial >= {1'b0, dsr_reg}) ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
    assign last_step = busy_reg && (cnt_reg == STEP_W'(WORD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/bounded_random_index_generator_top.sv @@
// Bounded random index generator: a xoshiro256** source whose draws are reduced
// modulo a positive bound by a bit-serial remainder unit. One input beat asks for
// batch_count indices (saturated to MAX_BATCH) below upper_bound; each index
// passes through one scramble step, one finishing add, 64 remainder steps with one
// quotient bit per cycle, one capture and one push, and the push waits while the
// output side stalls. A zero count or a bound of zero or below gives a single
// error beat and leaves the generator untouched. A seed write reloads all four
// state words by four SplitMix64 rounds, each built from two shift-add multiplies;
// no input beat is taken while it runs. Out of reset the generator holds the
// fixed xoshiro starting words.
`include "bounded_random_index_generator_top_assert.svh"

module bounded_random_index_generator_top #(
    parameter int MAX_BATCH = brig_pkg::DEFAULT_MAX_BATCH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  brig_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output brig_pkg::out_item_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [brig_pkg::WORD_W-1:0] cfg_data
);
    import brig_pkg::*;

    localparam int CNT_W = $clog2(MAX_BATCH + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCRAMBLE = 5'b00010,
        ST_FINISH   = 5'b00100,
        ST_MOD      = 5'b01000,
        ST_PUSH     = 5'b10000
    } gen_state_t;

    gen_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   remain_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic [WORD_W-1:0]  mix_reg;
    logic [WORD_W-1:0]  gen_words_reg [4];
    logic [BOUND_W-1:0] res_index_reg;
    logic               res_error_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               in_beat;
    logic               cfg_beat;
    logic               req_error;
    logic               out_free;
    logic               push_beat;
    logic               res_last;
    logic               seed_busy;
    seed_wr_t           seed_wr;
    logic               mod_start;
    logic               mod_done;
    logic [BOUND_W-1:0] mod_rem;
    logic [WORD_W-1:0]  draw;
    logic [WORD_W-1:0]  mul5;
    logic [WORD_W-1:0]  w2_x;
    logic [WORD_W-1:0]  w3_x;

    assign in_stall  = !(state_reg == ST_IDLE) || seed_busy || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !seed_busy;
    assign in_beat   = in_valid && !in_stall;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign req_error = (in_data.batch_count == 7'd0) || (in_data.upper_bound <= 32'sd0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign push_beat = (state_reg == ST_PUSH) && out_free;
    assign res_last  = res_error_reg || (remain_reg == CNT_W'(1));
    assign mod_start = (state_reg == ST_FINISH);

    brig_seed u_seed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_beat),
        .seed  (cfg_data),
        .busy  (seed_busy),
        .wr    (seed_wr)
    );

    brig_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (draw),
        .divisor   (bound_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // star-star output split by mix_reg: (s1*5) rotl 7 is registered, then *9
    assign mul5 = gen_words_reg[1] + (gen_words_reg[1] << 2);
    assign draw = mix_reg + (mix_reg << 3);
    assign w2_x = gen_words_reg[2] ^ gen_words_reg[0];
    assign w3_x = gen_words_reg[3] ^ gen_words_reg[1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = req_error ? ST_PUSH : ST_SCRAMBLE;
                end
            end
            ST_SCRAMBLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = res_last ? ST_IDLE : ST_SCRAMBLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            remain_reg       <= '0;
            res_error_reg    <= 1'b0;
            gen_words_reg[0] <= INIT_WORD0;
            gen_words_reg[1] <= INIT_WORD1;
            gen_words_reg[2] <= INIT_WORD2;
            gen_words_reg[3] <= INIT_WORD3;
        end
        else
        begin
            state_reg <= state_next;
            if (push_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_beat)
            begin
                res_error_reg <= req_error;
                if (int'(in_data.batch_count) > MAX_BATCH)
                begin
                    remain_reg <= CNT_W'(MAX_BATCH);
                end
                else
                begin
                    remain_reg <= CNT_W'(in_data.batch_count);
                end
            end
            else if (push_beat)
            begin
                remain_reg <= remain_reg - 1'b1;
            end

            if (seed_wr.valid)
            begin
                gen_words_reg[seed_wr.idx] <= seed_wr.word;
            end
            else if (state_reg == ST_SCRAMBLE)
            begin
                gen_words_reg[0] <= gen_words_reg[0] ^ w3_x;
                gen_words_reg[1] <= gen_words_reg[1] ^ w2_x;
                gen_words_reg[2] <= w2_x ^ (gen_words_reg[1] << XOSHIRO_SHIFT);
                gen_words_reg[3] <= rotl(w3_x, XOSHIRO_ROT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            bound_reg     <= in_data.upper_bound[BOUND_W-1:0];
            res_index_reg <= '0;
        end
        else if (state_reg == ST_MOD && mod_done)
        begin
            res_index_reg <= mod_rem;
        end

        if (state_reg == ST_SCRAMBLE)
        begin
            mix_reg <= rotl(mul5, 7);
        end

        if (push_beat)
        begin
            out_data_reg.index_value <= res_index_reg;
            out_data_reg.last_flag   <= res_last;
            out_data_reg.error_flag  <= res_error_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BRIG_ASSERT_NOW(a_seed_only_idle, seed_busy, state_reg == ST_IDLE, "draw during seeding")
    `BRIG_ASSERT_NOW(a_err_is_last, out_valid_reg && out_data_reg.error_flag,
        out_data_reg.last_flag && (out_data_reg.index_value == '0), "bad error beat")
    `BRIG_ASSERT_NOW(a_mod_done_in_mod, mod_done, state_reg == ST_MOD, "stray remainder")
    `BRIG_ASSERT_NEXT(a_push_fills_out, push_beat, out_valid_reg, "push lost")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import brig_pkg::*;

    localparam int unsigned BATCH_LIMIT = 64;

    localparam logic [63:0] START_W0 = 64'h180ec6d33cfd0aba;
    localparam logic [63:0] START_W1 = 64'hd5a61266f0c9392c;
    localparam logic [63:0] START_W2 = 64'ha9582618e03fc9aa;
    localparam logic [63:0] START_W3 = 64'h39abdc4529b1661c;
    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_B = 64'h94d049bb133111eb;
    localparam int unsigned XS_SHIFT = 17;
    localparam int unsigned XS_ROT = 45;

    localparam out_item_t ERR_BEAT = '{index_value: '0, last_flag: 1'b1, error_flag: 1'b1};

    typedef struct {
        logic [6:0]  count;
        logic [31:0] bound;
        bit          typed;
        out_item_t   want;
    } request_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [63:0] cfg_data;

    // set together with in_data: beat carries a hand-written expectation
    bit        req_typed;
    out_item_t req_want;

    logic [63:0] gen_word [4];
    out_item_t   pending_indices [$];
    int unsigned bad_beats;

    request_row_t directed_rows [16] = '{
        '{7'd0,   32'd100,        1'b1, ERR_BEAT},
        '{7'd0,   32'd0,          1'b1, ERR_BEAT},
        '{7'd1,   32'd0,          1'b1, ERR_BEAT},
        '{7'd5,   32'hffffffff,   1'b1, ERR_BEAT},
        '{7'd64,  32'h80000000,   1'b1, ERR_BEAT},
        '{7'd127, 32'hfffffffb,   1'b1, ERR_BEAT},
        '{7'd1,   32'd1,          1'b0, ERR_BEAT},
        '{7'd3,   32'd2,          1'b0, ERR_BEAT},
        '{7'd1,   32'h7fffffff,   1'b0, ERR_BEAT},
        '{7'd64,  32'd7,          1'b0, ERR_BEAT},
        '{7'd127, 32'd1000,       1'b0, ERR_BEAT},
        '{7'd65,  32'd3,          1'b0, ERR_BEAT},
        '{7'd2,   32'h40000000,   1'b0, ERR_BEAT},
        '{7'd9,   32'h55555555,   1'b0, ERR_BEAT},
        '{7'd1,   32'h2aaaaaaa,   1'b0, ERR_BEAT},
        '{7'd6,   32'd13,         1'b0, ERR_BEAT}
    };

    bounded_random_index_generator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rol64(logic [63:0] v, int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] xoshiro_next();
        logic [63:0] draw;
        logic [63:0] spill;
        draw  = rol64(gen_word[1] * 64'd5, 7) * 64'd9;
        spill = gen_word[1] << XS_SHIFT;
        gen_word[2] = gen_word[2] ^ gen_word[0];
        gen_word[3] = gen_word[3] ^ gen_word[1];
        gen_word[1] = gen_word[1] ^ gen_word[2];
        gen_word[0] = gen_word[0] ^ gen_word[3];
        gen_word[2] = gen_word[2] ^ spill;
        gen_word[3] = rol64(gen_word[3], XS_ROT);
        return draw;
    endfunction

    function automatic void splitmix_reload(logic [63:0] seed);
        logic [63:0] acc;
        logic [63:0] z;
        acc = seed;
        for (int w = 0; w < 4; w++)
        begin
            acc = acc + SM_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * SM_MUL_A;
            z = (z ^ (z >> 27)) * SM_MUL_B;
            gen_word[w] = z ^ (z >> 31);
        end
    endfunction

    function automatic void predict_indices(in_item_t req);
        int unsigned n;
        logic [31:0] bound;
        logic [63:0] draw;
        out_item_t   beat;
        n = 32'(req.batch_count);
        bound = req.upper_bound;
        if (n == 0 || bound == 0 || bound[31])
        begin
            pending_indices.push_back(ERR_BEAT);
            return;
        end
        if (n > BATCH_LIMIT)
            n = BATCH_LIMIT;
        for (int unsigned k = 0; k < n; k++)
        begin
            draw = xoshiro_next();
            beat.index_value = 31'(draw % {32'd0, bound});
            beat.last_flag = (k == n - 1);
            beat.error_flag = 1'b0;
            pending_indices.push_back(beat);
        end
    endfunction

    // predictor update and result check share one edge process
    always @(posedge clk)
    begin : scoreboard
        out_item_t want_beat;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                splitmix_reload(cfg_data);
            if (in_valid && !in_stall)
            begin
                if (req_typed)
                    pending_indices.push_back(req_want);
                else
                    predict_indices(in_data);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_indices.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("unexpected beat: idx=%0d last=%0b err=%0b",
                                 out_data.index_value, out_data.last_flag,
                                 out_data.error_flag);
                end
                else
                begin
                    want_beat = pending_indices.pop_front();
                    if (out_data.index_value !== want_beat.index_value ||
                        out_data.last_flag !== want_beat.last_flag ||
                        out_data.error_flag !== want_beat.error_flag)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     want_beat.index_value, want_beat.last_flag,
                                     want_beat.error_flag, out_data.index_value,
                                     out_data.last_flag, out_data.error_flag);
                    end
                end
            end
        end
    end

    // output backpressure: free runs, short stalls and the odd long one
    initial
    begin : stall_gen
        int unsigned run_len;
        bit          hold;
        out_stall = 1'b0;
        forever
        begin
            hold = ($urandom_range(0, 9) < 4);
            if (!hold)
                run_len = $urandom_range(1, 40);
            else if ($urandom_range(0, 9) < 8)
                run_len = $urandom_range(1, 3);
            else
                run_len = $urandom_range(10, 40);
            repeat (run_len)
            begin
                @(negedge clk);
                out_stall <= hold;
            end
        end
    end

    task automatic send_request(in_item_t req, bit typed, out_item_t want);
        @(negedge clk);
        in_valid  <= 1'b1;
        in_data   <= req;
        req_typed <= typed;
        req_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic sender_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_indices.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_seed(logic [63:0] seed);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            req.batch_count = 7'd0;
        else if (pick < 85)
            req.batch_count = 7'($urandom_range(1, 6));
        else if (pick < 95)
            req.batch_count = 7'($urandom_range(7, 64));
        else
            req.batch_count = 7'($urandom_range(65, 127));
        pick = $urandom_range(0, 99);
        if (pick < 2)
            req.upper_bound = 32'd0;
        else if (pick < 4)
            req.upper_bound = 32'hffffffff;
        else if (pick < 7)
            req.upper_bound = {1'b1, 31'($urandom())};
        else if (pick < 45)
            req.upper_bound = 32'($urandom_range(1, 16));
        else if (pick < 70)
            req.upper_bound = 32'($urandom_range(17, 100000));
        else
            req.upper_bound = {1'b0, 31'($urandom())};
        return req;
    endfunction

    task automatic random_phase(int unsigned n, bit pause_midway);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                drain_results();
            send_request(random_request(), 1'b0, ERR_BEAT);
            sender_gap();
        end
    endtask

    initial
    begin
        in_item_t req;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        req_typed = 1'b0;
        req_want  = ERR_BEAT;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        bad_beats = 0;
        gen_word[0] = START_W0;
        gen_word[1] = START_W1;
        gen_word[2] = START_W2;
        gen_word[3] = START_W3;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // generator still holds its starting words here
        foreach (directed_rows[i])
        begin
            req.batch_count = directed_rows[i].count;
            req.upper_bound = directed_rows[i].bound;
            send_request(req, directed_rows[i].typed, directed_rows[i].want);
            sender_gap();
        end

        write_seed(64'd0);
        random_phase(31, 1'b0);
        write_seed({64{1'b1}});
        random_phase(31, 1'b1);
        write_seed({$urandom(), $urandom()});
        random_phase(31, 1'b0);
        write_seed({$urandom(), $urandom()});
        random_phase(31, 1'b0);

        drain_results();
        repeat (100) @(negedge clk);
        if (bad_beats == 0 && pending_indices.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #(64'd50_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule
